// File: sv/tohq_pkg.sv
// tohq_pkg: shared types and codes for the time-ordered hit queue.
// Holds the controller/datapath command and status structs and result codes.
// No dependencies.
package tohq_pkg;

  localparam int TIME_W    = 64;
  localparam int STRIP_W   = 16;
  localparam int ADC_W     = 16;
  localparam int PAYLOAD_W = 1 + STRIP_W + ADC_W;
  localparam int ENTRY_W   = PAYLOAD_W + TIME_W;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_code_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } command_t;

  typedef struct packed {
    logic         latch;
    logic         clr_out;
    status_code_t stat;
    logic         push_init;
    logic         shift;
    logic         put;
    logic         put_front;
    logic         pop_head;
    logic         front_load;
    logic         report;
  } dp_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic cnt_zero;
    logic full;
    logic rd_gt;
    logic rem_last;
  } dp_stat_t;

endpackage

// File: sv/tohq_ctrl.sv
// tohq_ctrl: sequencer for the time-ordered hit queue.
// Steps each request through decode, insertion shift or pop, and report.
// Depends on tohq_pkg.
module tohq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tohq_pkg::dp_stat_t stat,
  output tohq_pkg::dp_cmd_t  cmd
);
  import tohq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DECODE   = 7'b0000010,
    S_PUSH_CMP = 7'b0000100,
    S_PUSH_PUT = 7'b0001000,
    S_POP_HEAD = 7'b0010000,
    S_POP_NEXT = 7'b0100000,
    S_REPORT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.stat  = ST_OK;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.clr_out = 1'b1;
        priority if (!stat.is_pop && stat.full) begin
          cmd.stat  = ST_FULL;
          state_nxt = S_REPORT;
        end else if (!stat.is_pop) begin
          cmd.push_init = 1'b1;
          state_nxt     = stat.cnt_zero ? S_PUSH_PUT : S_PUSH_CMP;
        end else if (stat.cnt_zero) begin
          cmd.stat  = ST_EMPTY;
          state_nxt = S_REPORT;
        end else begin
          state_nxt = S_POP_HEAD;
        end
      end
      S_PUSH_CMP: begin
        if (stat.rd_gt) begin
          cmd.shift = 1'b1;
          if (stat.rem_last) begin
            state_nxt = S_PUSH_PUT;
          end
        end else begin
          cmd.put   = 1'b1;
          state_nxt = S_REPORT;
        end
      end
      S_PUSH_PUT: begin
        cmd.put       = 1'b1;
        cmd.put_front = 1'b1;
        state_nxt     = S_REPORT;
      end
      S_POP_HEAD: begin
        cmd.pop_head = 1'b1;
        state_nxt    = S_POP_NEXT;
      end
      S_POP_NEXT: begin
        cmd.front_load = 1'b1;
        state_nxt      = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/tohq_dp.sv
// tohq_dp: datapath of the time-ordered hit queue.
// Circular sorted hit memory, head/count/hole pointers, plane watermarks, result registers.
// Depends on tohq_pkg; driven by tohq_ctrl.
module tohq_dp #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_command,
  input  logic [tohq_pkg::TIME_W-1:0]  in_hit_time,
  input  logic                        in_hit_plane,
  input  logic [tohq_pkg::STRIP_W-1:0] in_hit_strip,
  input  logic [tohq_pkg::ADC_W-1:0]   in_hit_adc,
  input  tohq_pkg::dp_cmd_t           cmd,
  output tohq_pkg::dp_stat_t          stat,
  output logic                        out_strobe,
  output logic                        out_valid,
  output logic [tohq_pkg::TIME_W-1:0]  out_time,
  output logic                        out_plane,
  output logic [tohq_pkg::STRIP_W-1:0] out_strip,
  output logic [tohq_pkg::ADC_W-1:0]   out_adc,
  output logic                        out_queue_ready,
  output logic                        out_queue_empty,
  output logic [1:0]                  out_status
);
  import tohq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [ENTRY_W-1:0]   mem_r [DEPTH];
  logic [ENTRY_W-1:0]   rd_data_r;
  logic [PW-1:0]        rd_addr;
  logic                 wr_en;
  logic [ENTRY_W-1:0]   wr_data;

  logic                 cmd_pop_r;
  logic [TIME_W-1:0]    t_r;
  logic [PAYLOAD_W-1:0] pay_r;
  logic [PW-1:0]        head_r;
  logic [CW-1:0]        count_r;
  logic [PW-1:0]        hole_r;
  logic [CW-1:0]        rem_r;
  logic [TIME_W-1:0]    latest0_r;
  logic [TIME_W-1:0]    latest1_r;
  logic [TIME_W-1:0]    front_r;

  logic                 strobe_r;
  logic                 valid_r;
  logic [TIME_W-1:0]    time_r;
  logic                 plane_r;
  logic [STRIP_W-1:0]   strip_r;
  logic [ADC_W-1:0]     adc_r;
  logic                 ready_r;
  logic                 empty_r;
  logic [1:0]           status_r;

  logic [PW:0]          tail_sum;
  logic [PW-1:0]        tail;
  logic [TIME_W-1:0]    rd_time;

  assign tail_sum = {1'b0, head_r} + (PW + 1)'(count_r);
  assign tail     = (tail_sum >= (PW + 1)'(DEPTH)) ? PW'(tail_sum - (PW + 1)'(DEPTH))
                                                    : tail_sum[PW-1:0];
  assign rd_time  = rd_data_r[TIME_W-1:0];

  assign stat.is_pop   = cmd_pop_r;
  assign stat.cnt_zero = (count_r == '0);
  assign stat.full     = (count_r == CW'(DEPTH));
  assign stat.rd_gt    = (rd_time > t_r);
  assign stat.rem_last = (rem_r == CW'(1));

  always_comb begin
    priority if (cmd.push_init) begin
      rd_addr = ptr_dec(tail);
    end else if (cmd.shift) begin
      rd_addr = ptr_dec(ptr_dec(hole_r));
    end else if (cmd.pop_head) begin
      rd_addr = ptr_inc(head_r);
    end else begin
      rd_addr = head_r;
    end
  end

  assign wr_en   = cmd.shift | cmd.put;
  assign wr_data = cmd.shift ? rd_data_r : {pay_r, t_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[hole_r] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_pop_r <= in_command;
      t_r       <= in_hit_time;
      pay_r     <= {in_hit_plane, in_hit_strip, in_hit_adc};
    end
    if (cmd.push_init) begin
      hole_r <= tail;
      rem_r  <= count_r;
    end else if (cmd.shift) begin
      hole_r <= ptr_dec(hole_r);
      rem_r  <= rem_r - 1'b1;
    end
    if (cmd.put_front) begin
      front_r <= t_r;
    end else if (cmd.front_load) begin
      front_r <= rd_time;
    end
    if (cmd.clr_out) begin
      valid_r  <= 1'b0;
      time_r   <= '0;
      plane_r  <= 1'b0;
      strip_r  <= '0;
      adc_r    <= '0;
      status_r <= cmd.stat;
    end else if (cmd.pop_head) begin
      valid_r <= 1'b1;
      time_r  <= rd_time;
      plane_r <= rd_data_r[ENTRY_W-1];
      strip_r <= rd_data_r[TIME_W+ADC_W +: STRIP_W];
      adc_r   <= rd_data_r[TIME_W +: ADC_W];
    end
    if (cmd.report) begin
      empty_r <= (count_r == '0);
      ready_r <= (count_r != '0) && (front_r < latest0_r) && (front_r < latest1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      latest0_r <= '0;
      latest1_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      strobe_r <= cmd.report;
      if (cmd.put) begin
        count_r <= count_r + 1'b1;
        if (pay_r[PAYLOAD_W-1]) begin
          if (t_r > latest1_r) begin
            latest1_r <= t_r;
          end
        end else begin
          if (t_r > latest0_r) begin
            latest0_r <= t_r;
          end
        end
      end else if (cmd.pop_head) begin
        count_r <= count_r - 1'b1;
        head_r  <= ptr_inc(head_r);
      end
    end
  end

  assign out_strobe      = strobe_r;
  assign out_valid       = valid_r;
  assign out_time        = time_r;
  assign out_plane       = plane_r;
  assign out_strip       = strip_r;
  assign out_adc         = adc_r;
  assign out_queue_ready = ready_r;
  assign out_queue_empty = empty_r;
  assign out_status      = status_r;

endmodule

// File: sv/time_ordered_hit_queue_core.sv
// time_ordered_hit_queue_core: one request at a time; busy is high from acceptance to report.
// A pop runs decode, head read, front reload, report; a rejected request decode, report.
// A push into an empty store runs decode, put, report; a push into a nonempty store first
// moves later entries up a slot, one per cycle, each a registered read then a memory write.
// The next request is taken at the edge that ends the one-cycle strobe; no receiver stall.
// Synchronous active-low reset empties the store and clears both plane watermarks.
module time_ordered_hit_queue_core #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [tohq_pkg::TIME_W-1:0]  in_hit_time,
  input  logic                        in_hit_plane,
  input  logic [tohq_pkg::STRIP_W-1:0] in_hit_strip,
  input  logic [tohq_pkg::ADC_W-1:0]   in_hit_adc,
  output logic                        out_strobe,
  output logic                        out_valid,
  output logic [tohq_pkg::TIME_W-1:0]  out_time,
  output logic                        out_plane,
  output logic [tohq_pkg::STRIP_W-1:0] out_strip,
  output logic [tohq_pkg::ADC_W-1:0]   out_adc,
  output logic                        out_queue_ready,
  output logic                        out_queue_empty,
  output logic [1:0]                  out_status
);
  import tohq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tohq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tohq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_hit_time     (in_hit_time),
    .in_hit_plane    (in_hit_plane),
    .in_hit_strip    (in_hit_strip),
    .in_hit_adc      (in_hit_adc),
    .cmd             (cmd),
    .stat            (stat),
    .out_strobe      (out_strobe),
    .out_valid       (out_valid),
    .out_time        (out_time),
    .out_plane       (out_plane),
    .out_strip       (out_strip),
    .out_adc         (out_adc),
    .out_queue_ready (out_queue_ready),
    .out_queue_empty (out_queue_empty),
    .out_status      (out_status)
  );

endmodule
